@@ rtl/core/assert_macros.svh @@
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

@@ rtl/core/mqrb_pkg.sv @@
package mqrb_pkg;

	localparam int QUEUE_COUNT_DEF = 4;
	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int DATA_WIDTH_DEF  = 32;
	localparam int NODE_WIDTH_DEF  = 8;

	// Fixed widths of the channel fields
	localparam int SEL_WIDTH       = 2;
	localparam int SEL_COUNT       = 2 ** SEL_WIDTH;
	localparam int PORT_NODE_WIDTH = 8;
	localparam int PORT_DATA_WIDTH = 32;

	typedef enum logic {
		OP_PRODUCE = 1'b0,
		OP_CONSUME = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                                opcode;
		logic [SEL_WIDTH-1:0]               queue_select;
		logic [PORT_NODE_WIDTH-1:0]         producer_node;
		logic signed [PORT_DATA_WIDTH-1:0]  payload;
	} req_item_t;

	typedef struct packed {
		status_t                            status;
		logic [PORT_NODE_WIDTH-1:0]         out_node;
		logic signed [PORT_DATA_WIDTH-1:0]  out_payload;
	} rsp_item_t;

endpackage

@@ rtl/core/mqrb_chan_if.sv @@
interface mqrb_chan_if #(
	parameter type item_t = logic
) ();

	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

@@ rtl/core/mqrb_entry_store.sv @@
module mqrb_entry_store #(
	parameter int DEPTH = mqrb_pkg::QUEUE_COUNT_DEF * mqrb_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = mqrb_pkg::NODE_WIDTH_DEF + mqrb_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/mqrb_ctrl_store.sv @@
module mqrb_ctrl_store #(
	parameter int DEPTH = mqrb_pkg::QUEUE_COUNT_DEF,
	parameter int WIDTH = 10
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// an entry never written reads as all zero (pointers and occupancy cleared)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rd_vld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

@@ rtl/core/multi_queue_ring_buffer_unit.sv @@
// Multi-queue circular FIFO over one shared entry store.
// req channel: one produce or consume per transfer, addressed to a queue.
// rsp channel: exactly one result per request, in request order: status,
//   node id and data word (dequeued entry, or the echoed request on produce).
// A request is accepted only while the sequencer is idle. Its steps:
//   read the queue's pointers and occupancy, then check and write them back
//   while the entry is written or read, then load the result register. A new
//   request is not accepted until the result of the last one has been loaded
//   into the result register.
// A full produce or empty consume returns a reject status and changes nothing.
// Reset clears every queue to empty at once (valid bits on the control
//   store); no clearing pass is needed and the entry store is not cleared.
// If rsp stalls, the result waits in its register; the next request is still
//   accepted and worked on, and its result is held back until the register
//   frees up.
module multi_queue_ring_buffer_unit #(
	parameter int QUEUE_COUNT = mqrb_pkg::QUEUE_COUNT_DEF,
	parameter int QUEUE_DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_WIDTH  = mqrb_pkg::DATA_WIDTH_DEF,
	parameter int NODE_WIDTH  = mqrb_pkg::NODE_WIDTH_DEF
) (
	input logic         clk,
	input logic         arst_n,
	mqrb_chan_if.sink   req,
	mqrb_chan_if.source rsp
);

	`include "assert_macros.svh"

	localparam int QW    = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
	localparam int PW    = $clog2(QUEUE_DEPTH);
	localparam int OW    = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = QUEUE_COUNT * QUEUE_DEPTH;
	localparam int AW    = $clog2(SLOTS);
	localparam int CW    = 2 * PW + OW;
	localparam int EW    = NODE_WIDTH + DATA_WIDTH;
	localparam int PNW   = mqrb_pkg::PORT_NODE_WIDTH;
	localparam int PDW   = mqrb_pkg::PORT_DATA_WIDTH;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CTRL = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t state_q;

	mqrb_pkg::op_t      op_q;
	logic [QW-1:0]      q_q;
	logic [PNW-1:0]     node_q;
	logic [PDW-1:0]     data_q;

	mqrb_pkg::status_t  status_q;
	logic               from_mem_q;
	logic [PNW-1:0]     res_node_q;
	logic [PDW-1:0]     res_data_q;

	logic                rsp_valid_q;
	mqrb_pkg::rsp_item_t rsp_data_q;

	logic [QW-1:0] q_sel;
	logic          req_xfer;

	logic [CW-1:0] ctrl_rdata;
	logic [CW-1:0] ctrl_wdata;
	logic          ctrl_we;
	logic [PW-1:0] c_wp, c_rp, n_wp, n_rp;
	logic [OW-1:0] c_occ, n_occ;
	logic          full, empty, do_push, do_pop;

	logic [AW-1:0] slot_base, wslot, rslot;
	logic          ent_we, ent_re;
	logic [EW-1:0] ent_wdata, ent_rdata;

	logic          rsp_load;

	// queue select reduced modulo the queue count
	always_comb begin
		q_sel = '0;
		for (int i = 0; i < mqrb_pkg::SEL_COUNT; i++) begin
			if (req.data.queue_select == mqrb_pkg::SEL_WIDTH'(i)) begin
				q_sel = QW'(i % QUEUE_COUNT);
			end
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;

	mqrb_ctrl_store #(
		.DEPTH (QUEUE_COUNT),
		.WIDTH (CW)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (ctrl_we),
		.waddr  (q_q),
		.wdata  (ctrl_wdata),
		.re     (req_xfer),
		.raddr  (q_sel),
		.rdata  (ctrl_rdata)
	);

	assign {c_wp, c_rp, c_occ} = ctrl_rdata;

	assign full    = (c_occ >= OW'(QUEUE_DEPTH));
	assign empty   = (c_occ == '0);
	assign do_push = (state_q == S_CTRL) && (op_q == mqrb_pkg::OP_PRODUCE) && !full;
	assign do_pop  = (state_q == S_CTRL) && (op_q == mqrb_pkg::OP_CONSUME) && !empty;

	assign n_wp  = (c_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : c_wp + 1'b1;
	assign n_rp  = (c_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : c_rp + 1'b1;
	assign n_occ = do_push ? c_occ + 1'b1 : c_occ - 1'b1;

	// control write-back in the check cycle, before the next request's read
	assign ctrl_we    = do_push || do_pop;
	assign ctrl_wdata = {(do_push ? n_wp : c_wp), (do_pop ? n_rp : c_rp), n_occ};

	assign slot_base = AW'(q_q) * AW'(QUEUE_DEPTH);
	assign wslot     = slot_base + AW'(c_wp);
	assign rslot     = slot_base + AW'(c_rp);

	assign ent_we    = do_push;
	assign ent_re    = do_pop;
	assign ent_wdata = {NODE_WIDTH'(node_q), DATA_WIDTH'(data_q)};

	mqrb_entry_store #(
		.DEPTH (SLOTS),
		.WIDTH (EW)
	) u_entry (
		.clk   (clk),
		.we    (ent_we),
		.waddr (wslot),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (rslot),
		.rdata (ent_rdata)
	);

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_xfer) begin
						state_q <= S_CTRL;
					end
				end
				S_CTRL: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q   <= req.data.opcode;
			q_q    <= q_sel;
			node_q <= req.data.producer_node;
			data_q <= $unsigned(req.data.payload);
		end
		if (state_q == S_CTRL) begin
			from_mem_q <= do_pop;
			if (op_q == mqrb_pkg::OP_PRODUCE) begin
				status_q   <= full ? mqrb_pkg::STAT_FULL : mqrb_pkg::STAT_DONE;
				res_node_q <= node_q;
				res_data_q <= data_q;
			end else begin
				status_q   <= empty ? mqrb_pkg::STAT_EMPTY : mqrb_pkg::STAT_DONE;
				res_node_q <= '0;
				res_data_q <= '0;
			end
		end
		if (rsp_load) begin
			rsp_data_q.status <= status_q;
			if (from_mem_q) begin
				rsp_data_q.out_node    <= PNW'(ent_rdata[EW-1:DATA_WIDTH]);
				rsp_data_q.out_payload <= $signed(PDW'(ent_rdata[DATA_WIDTH-1:0]));
			end else begin
				rsp_data_q.out_node    <= res_node_q;
				rsp_data_q.out_payload <= $signed(res_data_q);
			end
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

	`ASSERT_NEXT(a_xfer_to_ctrl, clk, arst_n, req_xfer, state_q == S_CTRL)
	`ASSERT_IMPL(a_occ_bound, clk, arst_n, state_q == S_CTRL, c_occ <= OW'(QUEUE_DEPTH))
	`ASSERT_IMPL(a_wb_in_ctrl, clk, arst_n, ctrl_we || ent_we || ent_re, state_q == S_CTRL)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, (state_q == S_DONE) && rsp_valid_q && !rsp.ready,
		state_q == S_DONE)

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	localparam int NQ    = mqrb_pkg::QUEUE_COUNT_DEF;
	localparam int DEPTH = mqrb_pkg::QUEUE_DEPTH_DEF;
	localparam int NW    = mqrb_pkg::PORT_NODE_WIDTH;
	localparam int DW    = mqrb_pkg::PORT_DATA_WIDTH;
	localparam int SW    = mqrb_pkg::SEL_WIDTH;

	logic clk;
	logic arst_n;

	mqrb_chan_if #(.item_t(mqrb_pkg::req_item_t)) req_ch ();
	mqrb_chan_if #(.item_t(mqrb_pkg::rsp_item_t)) rsp_ch ();

	multi_queue_ring_buffer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the queues
	logic [NW-1:0]        model_node [NQ][DEPTH];
	logic signed [DW-1:0] model_data [NQ][DEPTH];
	int unsigned          model_wr   [NQ];
	int unsigned          model_rd   [NQ];
	int unsigned          model_fill [NQ];

	mqrb_pkg::rsp_item_t pending_results [$];
	int                  error_count;

	int req_gap_max;
	int rsp_stall_max;
	int rsp_hold_len;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic mqrb_pkg::rsp_item_t queue_model_step(mqrb_pkg::req_item_t it);
		mqrb_pkg::rsp_item_t r;
		int                  q;
		q = int'(it.queue_select) % NQ;
		r.status      = mqrb_pkg::STAT_DONE;
		r.out_node    = '0;
		r.out_payload = '0;
		if (it.opcode == mqrb_pkg::OP_PRODUCE) begin
			r.out_node    = it.producer_node;
			r.out_payload = it.payload;
			if (model_fill[q] >= DEPTH) begin
				r.status = mqrb_pkg::STAT_FULL;
			end else begin
				model_node[q][model_wr[q]] = it.producer_node;
				model_data[q][model_wr[q]] = it.payload;
				model_wr[q]   = (model_wr[q] + 1) % DEPTH;
				model_fill[q] = model_fill[q] + 1;
			end
		end else begin
			if (model_fill[q] == 0) begin
				r.status = mqrb_pkg::STAT_EMPTY;
			end else begin
				r.out_node    = model_node[q][model_rd[q]];
				r.out_payload = model_data[q][model_rd[q]];
				model_rd[q]   = (model_rd[q] + 1) % DEPTH;
				model_fill[q] = model_fill[q] - 1;
			end
		end
		return r;
	endfunction

	// Offer one request after a random gap; returns at the edge of its transfer
	task automatic send_request(input mqrb_pkg::op_t op, input logic [SW-1:0] sel,
			input logic [NW-1:0] node,
			input logic signed [DW-1:0] data);
		mqrb_pkg::req_item_t it;
		int                  gap;
		it.opcode        = op;
		it.queue_select  = sel;
		it.producer_node = node;
		it.payload       = data;
		gap = $urandom_range(0, req_gap_max);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(queue_model_step(it));
	endtask

	task automatic send_random_request(input int produce_pct);
		mqrb_pkg::op_t op;
		if ($urandom_range(0, 99) < 15)
			op = mqrb_pkg::op_t'($urandom_range(0, 1));
		else if ($urandom_range(0, 99) < produce_pct)
			op = mqrb_pkg::OP_PRODUCE;
		else
			op = mqrb_pkg::OP_CONSUME;
		send_request(op, SW'($urandom_range(0, mqrb_pkg::SEL_COUNT - 1)),
			NW'($urandom_range(0, 255)), $signed(DW'($urandom)));
	endtask

	task automatic test_directed();
		req_gap_max   = 3;
		rsp_stall_max = 3;
		// consume from empty queue, junk in the ignored fields
		send_request(mqrb_pkg::OP_CONSUME, 2'd0, 8'hff, 32'sh7fffffff);
		send_request(mqrb_pkg::OP_PRODUCE, 2'd0, 8'h00, 32'sh80000000);
		send_request(mqrb_pkg::OP_PRODUCE, 2'd0, 8'hff, 32'sh7fffffff);
		send_request(mqrb_pkg::OP_CONSUME, 2'd0, 8'h5a, 32'sh0);
		send_request(mqrb_pkg::OP_CONSUME, 2'd0, 8'ha5, -32'sd1);
		// fill to the brim, one over, then drain past empty
		for (int i = 0; i < DEPTH; i++)
			send_request(mqrb_pkg::OP_PRODUCE, 2'd3, i[7:0] ^ 8'hc3,
				(i % 2) ? -32'sd1 : 32'sd0);
		send_request(mqrb_pkg::OP_PRODUCE, 2'd3, 8'h81, 32'sh12345678);
		for (int i = 0; i < DEPTH; i++)
			send_request(mqrb_pkg::OP_CONSUME, 2'd3, 8'h00, 32'sh0);
		send_request(mqrb_pkg::OP_CONSUME, 2'd3, 8'h7e, 32'sh80000001);
	endtask

	task automatic test_random_traffic(input int count, input int produce_pct,
			input int gap_max, input int stall_max);
		req_gap_max   = gap_max;
		rsp_stall_max = stall_max;
		repeat (count) send_random_request(produce_pct);
	endtask

	// Long hold on rsp while requests keep coming back to back
	task automatic test_output_stall();
		req_gap_max   = 0;
		rsp_stall_max = 0;
		rsp_hold_len  = 150;
		repeat (24) send_random_request(50);
	endtask

	task automatic wait_for_drain();
		int guard;
		guard = 0;
		while (pending_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, pending_results.size());
			error_count++;
		end
	endtask

	// rsp ready, with a stall drawn per transfer
	initial begin
		int stall;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold_len > 0) begin
				stall        = rsp_hold_len;
				rsp_hold_len = 0;
			end else begin
				stall = $urandom_range(0, rsp_stall_max);
			end
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	always @(posedge clk) begin : check_results
		mqrb_pkg::rsp_item_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d node %0d payload %0d", $time,
					rsp_ch.data.status, rsp_ch.data.out_node, rsp_ch.data.out_payload);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, rsp_ch.data.status);
					error_count++;
				end
				if (rsp_ch.data.out_node !== want.out_node) begin
					$display("%0t: out_node expected %0d actual %0d", $time,
						want.out_node, rsp_ch.data.out_node);
					error_count++;
				end
				if (rsp_ch.data.out_payload !== want.out_payload) begin
					$display("%0t: out_payload expected %0d actual %0d", $time,
						want.out_payload, rsp_ch.data.out_payload);
					error_count++;
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		error_count   = 0;
		req_gap_max   = 0;
		rsp_stall_max = 0;
		rsp_hold_len  = 0;
		for (int q = 0; q < NQ; q++) begin
			model_wr[q]   = 0;
			model_rd[q]   = 0;
			model_fill[q] = 0;
		end
		arst_n       = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(100, 75, 13, 13);
		test_random_traffic(100, 25, 0, 0);
		test_output_stall();
		test_random_traffic(100, 70, 0, 13);
		test_random_traffic(100, 30, 13, 0);

		req_ch.valid <= 1'b0;
		wait_for_drain();

		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ multi_queue_ring_buffer_unit.f @@
+incdir+rtl/core
rtl/core/mqrb_pkg.sv
rtl/core/mqrb_chan_if.sv
rtl/core/mqrb_entry_store.sv
rtl/core/mqrb_ctrl_store.sv
rtl/core/multi_queue_ring_buffer_unit.sv
verif/tb_top.sv
